// ===== design/rotq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rotq_pkg;

    localparam int MAX_DIM     = 256;
    localparam int DIM_W       = 9;
    localparam int COORD_W     = 8;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = 16;
    localparam int COUNT_W     = 17;
    localparam int CHAN_W      = 8;
    localparam int PIX_W       = 3 * CHAN_W;
    localparam int CFG_IDX_W   = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_MODE = 2'd2;

    // request kinds carried on s_tuser
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        ROT_NONE = 2'd0,
        ROT_90   = 2'd1,
        ROT_180  = 2'd2,
        ROT_270  = 2'd3
    } rot_mode_t;

    localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

    // width or height register as used: 0 acts as 1, above the maximum clips
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] reg_val);
        logic [DIM_W-1:0] res;
        if (reg_val == '0) begin
            res = DIM_W'(1);
        end else if (reg_val > DIM_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = reg_val;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/rotq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rotq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // read data holds while re is low
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/image_rotate_quadrant.sv =====
`timescale 1ns / 1ps
`default_nettype none

// quadrant rotation engine for 24-bit rgb frames
// s_ channel: one request per beat; s_tuser selects load (0) or drain (1),
//   s_tdata carries the pixel of a load and is ignored on a drain
// loads fill the frame store in source raster order up to width * height
//   pixels; loads beyond a full frame are dropped
// drains issued before the frame is full give no result and change nothing
// each drain on a full frame gives one pixel of the rotated frame on m_,
//   in output raster order, with m_tlast on the final pixel; that pixel
//   clears the load count and the drain position for the next frame
// path: a drain request goes through the address multiply plus store read,
//   then the output register, before its pixel shows on m_
// throughput: one request per cycle while s_tready is high; the frame store
//   has one write and one read port, and the drain address takes one 8 x 9 multiply
// stall: a held m_tready keeps the output register and the read stage
//   full, and s_tready drops only once both are occupied
// reset (aresetn low, synchronous): config returns to 256 x 256, no rotation,
//   frame emptied; store contents are not cleared, no clearing pass
// config writes (cfg_wr_en) abort the frame in progress; write only while idle
module image_rotate_quadrant
    import rotq_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [DIM_W-1:0]     cfg_wdata,
    // request channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [PIX_W-1:0]     s_tdata,   // in_red, in_green, in_blue
    input  wire logic                 s_tuser,   // func
    // result channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [PIX_W-1:0]     m_tdata,   // out_red, out_green, out_blue
    output logic                      m_tlast    // last_pixel
);

    // configuration registers
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    rot_mode_t        mode_reg;

    // frame state
    logic [COUNT_W-1:0] loaded_count_reg, loaded_count_next;
    logic [COORD_W-1:0] drain_column_reg, drain_column_next;
    logic [COORD_W-1:0] drain_row_reg, drain_row_next;

    // read stage and output register
    logic             rd_valid_reg;
    logic             rd_last_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_data_reg;
    logic             out_last_reg;

    logic [DIM_W-1:0]   eff_w, eff_h, out_w, out_h;
    logic [COUNT_W-1:0] total;
    logic               frame_full;
    logic               accept, load_fire, drain_fire, out_free, rd_free;
    logic               last_c;
    logic [COORD_W-1:0] mul_a;
    logic [COUNT_W-1:0] prod, src_full;
    logic [ADDR_W-1:0]  src_addr;
    logic [PIX_W-1:0]   ram_rdata;
    logic               cfg_hit;

    assign eff_w = eff_dim(width_reg);
    assign eff_h = eff_dim(height_reg);
    assign total = COUNT_W'(eff_w) * COUNT_W'(eff_h);

    // 90 and 270 swap the output dimensions
    always_comb begin
        case (mode_reg)
            ROT_90, ROT_270: begin
                out_w = eff_h;
                out_h = eff_w;
            end
            default: begin
                out_w = eff_w;
                out_h = eff_h;
            end
        endcase
    end

    assign frame_full = (loaded_count_reg >= total);

    // handshake: read stage frees when the output register can take its data
    assign out_free   = !out_valid_reg || m_tready;
    assign rd_free    = !rd_valid_reg || out_free;
    assign s_tready   = rd_free;
    assign accept     = s_tvalid && s_tready;
    assign load_fire  = accept && (s_tuser == FUNC_LOAD) && !frame_full;
    assign drain_fire = accept && (s_tuser == FUNC_DRAIN) && frame_full;

    assign last_c = ({1'b0, drain_column_reg} == out_w - DIM_W'(1))
                 && ({1'b0, drain_row_reg} == out_h - DIM_W'(1));

    // source address: one shared multiply by the source width
    always_comb begin
        case (mode_reg)
            ROT_90:  mul_a = COORD_W'(eff_h - DIM_W'(1) - {1'b0, drain_column_reg});
            ROT_270: mul_a = drain_column_reg;
            default: mul_a = drain_row_reg;
        endcase
    end

    assign prod = COUNT_W'(mul_a) * COUNT_W'(eff_w);

    always_comb begin
        case (mode_reg)
            ROT_90: begin
                src_full = prod + COUNT_W'(drain_row_reg);
            end
            ROT_180: begin
                src_full = total - COUNT_W'(1) - (prod + COUNT_W'(drain_column_reg));
            end
            ROT_270: begin
                src_full = prod + COUNT_W'(eff_w - DIM_W'(1) - {1'b0, drain_row_reg});
            end
            default: begin
                src_full = prod + COUNT_W'(drain_column_reg);
            end
        endcase
    end

    assign src_addr = src_full[ADDR_W-1:0];

    rotq_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_frame_store (
        .clk   (aclk),
        .we    (load_fire),
        .waddr (loaded_count_reg[ADDR_W-1:0]),
        .wdata (s_tdata),
        .re    (drain_fire),
        .raddr (src_addr),
        .rdata (ram_rdata)
    );

    assign cfg_hit = cfg_wr_en && ((cfg_addr == CFG_IMAGE_WIDTH)
                                || (cfg_addr == CFG_IMAGE_HEIGHT)
                                || (cfg_addr == CFG_ROTATION_MODE));

    // frame counters
    always_comb begin
        loaded_count_next = loaded_count_reg;
        drain_column_next = drain_column_reg;
        drain_row_next    = drain_row_reg;
        if (cfg_hit) begin
            loaded_count_next = '0;
            drain_column_next = '0;
            drain_row_next    = '0;
        end else if (load_fire) begin
            loaded_count_next = loaded_count_reg + COUNT_W'(1);
        end else if (drain_fire) begin
            if (last_c) begin
                loaded_count_next = '0;
                drain_column_next = '0;
                drain_row_next    = '0;
            end else if ({1'b0, drain_column_reg} == out_w - DIM_W'(1)) begin
                drain_column_next = '0;
                drain_row_next    = drain_row_reg + COORD_W'(1);
            end else begin
                drain_column_next = drain_column_reg + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg        <= DIM_RESET;
            height_reg       <= DIM_RESET;
            mode_reg         <= ROT_NONE;
            loaded_count_reg <= '0;
            drain_column_reg <= '0;
            drain_row_reg    <= '0;
            rd_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_IMAGE_WIDTH:   width_reg  <= cfg_wdata;
                    CFG_IMAGE_HEIGHT:  height_reg <= cfg_wdata;
                    CFG_ROTATION_MODE: mode_reg   <= rot_mode_t'(cfg_wdata[1:0]);
                    default: ;
                endcase
            end
            loaded_count_reg <= loaded_count_next;
            drain_column_reg <= drain_column_next;
            drain_row_reg    <= drain_row_next;
            if (rd_free) begin
                rd_valid_reg <= drain_fire;
            end
            if (out_free) begin
                out_valid_reg <= rd_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (drain_fire) begin
            rd_last_reg <= last_c;
        end
        if (out_free && rd_valid_reg) begin
            out_data_reg <= ram_rdata;
            out_last_reg <= rd_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        loaded_count_reg <= total)
        else $error("load count beyond frame size");

    a_drain_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, drain_column_reg} < out_w) && ({1'b0, drain_row_reg} < out_h))
        else $error("drain position outside output frame");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_fire && last_c |=> loaded_count_reg == '0)
        else $error("frame not cleared after last pixel");

    a_read_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_fire |-> !load_fire && frame_full)
        else $error("store read and write in the same cycle");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_image_rotate_quadrant.sv =====
`timescale 1ns / 1ps

module tb_image_rotate_quadrant;
    import rotq_pkg::*;

    // idle stretch allowed between two handshakes on either channel before giving up
    localparam int STALL_LIMIT   = 4000;
    // cycles let pass after the last pixel, pipeline is two deep
    localparam int DRAIN_SETTLE  = 6;
    // stimulus stops once this many meaningful requests are queued
    localparam int RANDOM_ITEMS  = 1100;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] pixel;   // red, green, blue from the lowest bit up
    } rgb_request_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last;
    } rgb_pixel_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // block inputs, all known from time zero
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [DIM_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic [PIX_W-1:0]     s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tready  = 1'b0;

    // block outputs
    logic                 s_tready;
    logic                 m_tvalid;
    logic [PIX_W-1:0]     m_tdata;
    logic                 m_tlast;

    image_rotate_quadrant DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // in_red, in_green, in_blue
        .s_tuser   (s_tuser),    // func
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // out_red, out_green, out_blue
        .m_tlast   (m_tlast)     // last_pixel
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // requests waiting for the driver, and rotated pixels still owed by the block
    rgb_request_t req_queue[$];
    rgb_pixel_t   pixels_due[$];

    // shadow of the engine: frame store, counters, registers
    logic [PIX_W-1:0] frame_mem [0:STORE_DEPTH-1];
    int               pix_loaded;
    int               out_col;
    int               out_row;
    logic [DIM_W-1:0] width_reg_m;
    logic [DIM_W-1:0] height_reg_m;
    rot_mode_t        mode_m;

    // bookkeeping
    int  reqs_issued   = 0;
    int  reqs_accepted = 0;
    int  counted_items = 0;
    int  fail_count    = 0;
    int  idle_cycles   = 0;
    bit  s_fire        = 1'b0;
    int  s_gap_left    = 0;
    int  m_stall_left  = 0;
    int  s_lvl         = 0;
    int  m_lvl         = 0;

    // register values as the stimulus side last wrote them
    logic [DIM_W-1:0] tb_width  = DIM_RESET;
    logic [DIM_W-1:0] tb_height = DIM_RESET;

    // dimension as the engine uses it: zero acts as one, large values clip
    function automatic int dim_in_use(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    // idle length: none at level 0; above it some none, some short, a few long
    function automatic int pick_gap(input int lvl);
        int r;
        r = $urandom_range(0, 99);
        if (lvl == 0) begin
            return 0;
        end
        if (r < ((lvl == 1) ? 75 : 40)) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] p;
        int               r;
        for (int c = 0; c < 3; c++) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                p[c*CHAN_W +: CHAN_W] = '0;
            end else if (r == 1) begin
                p[c*CHAN_W +: CHAN_W] = '1;
            end else begin
                p[c*CHAN_W +: CHAN_W] = CHAN_W'($urandom);
            end
        end
        return p;
    endfunction

    // any register write aborts the frame in progress
    task automatic shadow_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [DIM_W-1:0] val);
        case (idx)
            CFG_IMAGE_WIDTH: begin
                width_reg_m = val;
            end
            CFG_IMAGE_HEIGHT: begin
                height_reg_m = val;
            end
            CFG_ROTATION_MODE: begin
                mode_m = rot_mode_t'(val[1:0]);
            end
            default: begin
                return;
            end
        endcase
        pix_loaded = 0;
        out_col    = 0;
        out_row    = 0;
    endtask

    // load fills the store in raster order; drain walks the rotated frame
    task automatic rotate_predict(input logic func, input logic [PIX_W-1:0] data);
        int               w;
        int               h;
        int               total;
        int               ow;
        int               oh;
        int               ox;
        int               oy;
        int               src;
        logic [PIX_W-1:0] pix;
        rgb_pixel_t       res;
        w     = dim_in_use(width_reg_m);
        h     = dim_in_use(height_reg_m);
        total = w * h;
        if (func == FUNC_LOAD) begin
            // a load on a full frame is dropped
            if (pix_loaded < total) begin
                frame_mem[pix_loaded] = data;
                pix_loaded++;
            end
            return;
        end
        // a drain on a partial frame does nothing
        if (pix_loaded < total) begin
            return;
        end
        if (mode_m == ROT_90 || mode_m == ROT_270) begin
            ow = h;
            oh = w;
        end else begin
            ow = w;
            oh = h;
        end
        ox = (out_col >= ow) ? ow - 1 : out_col;
        oy = (out_row >= oh) ? oh - 1 : out_row;
        case (mode_m)
            ROT_90: begin
                src = (h - 1 - ox) * w + oy;
            end
            ROT_180: begin
                src = total - 1 - (oy * w + ox);
            end
            ROT_270: begin
                src = ox * w + (w - 1 - oy);
            end
            default: begin
                src = oy * w + ox;
            end
        endcase
        pix       = frame_mem[src];
        res.red   = pix[0 +: CHAN_W];
        res.green = pix[CHAN_W +: CHAN_W];
        res.blue  = pix[2*CHAN_W +: CHAN_W];
        res.last  = (ox == ow - 1) && (oy == oh - 1);
        pixels_due.push_back(res);
        // final pixel clears the frame for the next load
        if (res.last) begin
            pix_loaded = 0;
            out_col    = 0;
            out_row    = 0;
        end else if (ox + 1 >= ow) begin
            out_col = 0;
            out_row = oy + 1;
        end else begin
            out_col = ox + 1;
            out_row = oy;
        end
    endtask

    task automatic report_failure(input rgb_pixel_t want, input rgb_pixel_t got,
                                  input bit none_due);
        if (fail_count < REPORT_LIMIT) begin
            if (none_due) begin
                $display("%0t: unexpected pixel r=%02h g=%02h b=%02h last=%0b",
                         $time, got.red, got.green, got.blue, got.last);
            end else begin
                $write("%0t: pixel mismatch exp r=%02h g=%02h b=%02h last=%0b, ",
                       $time, want.red, want.green, want.blue, want.last);
                $display("got r=%02h g=%02h b=%02h last=%0b",
                         got.red, got.green, got.blue, got.last);
            end
        end
        fail_count++;
    endtask

    task automatic check_pixel();
        rgb_pixel_t got;
        rgb_pixel_t want;
        got.red   = m_tdata[0 +: CHAN_W];
        got.green = m_tdata[CHAN_W +: CHAN_W];
        got.blue  = m_tdata[2*CHAN_W +: CHAN_W];
        got.last  = m_tlast;
        if (pixels_due.size() == 0) begin
            report_failure(got, got, 1'b1);
        end else begin
            want = pixels_due.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.last !== want.last) begin
                report_failure(want, got, 1'b0);
            end
        end
    endtask

    // monitor: everything sampled at the rising edge
    always @(posedge aclk) begin
        s_fire = 1'b0;
        if (!aresetn) begin
            width_reg_m  = DIM_RESET;
            height_reg_m = DIM_RESET;
            mode_m       = ROT_NONE;
            pix_loaded   = 0;
            out_col      = 0;
            out_row      = 0;
            idle_cycles  = 0;
        end else begin
            if (cfg_wr_en) begin
                shadow_reg_write(cfg_addr, cfg_wdata);
            end
            if (s_tvalid && s_tready) begin
                s_fire = 1'b1;
                rotate_predict(s_tuser, s_tdata);
                reqs_accepted++;
            end
            if (m_tvalid && m_tready) begin
                check_pixel();
            end
            // watchdog: any handshake restarts the count
            if (s_fire || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog expired after %0d idle cycles", idle_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // request driver: holds a request until taken, random gaps between
    always @(negedge aclk) begin
        rgb_request_t item;
        if (s_tvalid && !s_fire) begin
            // hold until accepted
        end else if (s_gap_left > 0) begin
            s_tvalid <= 1'b0;
            s_gap_left--;
        end else if (req_queue.size() > 0) begin
            item = req_queue.pop_front();
            s_tvalid   <= 1'b1;
            s_tuser    <= item.func;
            s_tdata    <= item.pixel;
            s_gap_left = pick_gap(s_lvl);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (m_stall_left > 0) begin
            m_tready <= 1'b0;
            m_stall_left--;
        end else begin
            m_tready <= 1'b1;
            m_stall_left = pick_gap(m_lvl);
        end
    end

    task automatic push_req(input logic func, input logic [PIX_W-1:0] pix,
                            input bit counts);
        rgb_request_t item;
        item.func  = func;
        item.pixel = pix;
        req_queue.push_back(item);
        reqs_issued++;
        if (counts) begin
            counted_items++;
        end
    endtask

    // all requests taken and all pixels back, then let the pipeline settle
    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (reqs_accepted != reqs_issued || pixels_due.size() != 0);
        repeat (DRAIN_SETTLE) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == CFG_IMAGE_WIDTH) begin
            tb_width = val;
        end else if (idx == CFG_IMAGE_HEIGHT) begin
            tb_height = val;
        end
    endtask

    task automatic finish_cfg();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // one clean frame: loads with stray early drains, then drains with
    // stray loads that the full frame drops
    task automatic queue_frame(input int npix);
        int extra;
        for (int k = 0; k < npix; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                push_req(FUNC_DRAIN, rand_pixel(), 1'b0);
            end
            push_req(FUNC_LOAD, rand_pixel(), 1'b1);
        end
        if ($urandom_range(0, 3) == 0) begin
            extra = $urandom_range(1, 3);
            for (int k = 0; k < extra; k++) begin
                push_req(FUNC_LOAD, rand_pixel(), 1'b0);
            end
        end
        for (int k = 0; k < npix; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                push_req(FUNC_LOAD, rand_pixel(), 1'b0);
            end
            push_req(FUNC_DRAIN, rand_pixel(), 1'b1);
        end
    endtask

    task automatic random_phase(input int phase_no);
        int               pick;
        int               mask;
        int               tmp;
        int               j;
        int               npix;
        int               nseg;
        int               kind;
        int               nload;
        int               ndrain;
        int               order[3];
        logic [DIM_W-1:0] wv;
        logic [DIM_W-1:0] hv;
        logic [DIM_W-1:0] mv;
        pick = $urandom_range(0, 99);
        // sizes: mostly tiny frames, a few at the limits of the registers
        if (phase_no == 3) begin
            if ($urandom_range(0, 1) == 0) begin
                wv = DIM_W'(MAX_DIM);
                hv = '0;
            end else begin
                wv = DIM_W'(1);
                hv = '1;
            end
        end else if (pick < 70) begin
            wv = DIM_W'($urandom_range(1, 8));
            hv = DIM_W'($urandom_range(1, 8));
        end else if (pick < 85) begin
            wv = DIM_W'($urandom_range(1, 16));
            hv = DIM_W'($urandom_range(1, 16));
        end else if (pick < 92) begin
            wv = '0;
            hv = DIM_W'($urandom_range(1, 8));
        end else begin
            wv = DIM_W'($urandom_range(200, 511));
            hv = DIM_W'($urandom_range(0, 1));
        end
        if ($urandom_range(0, 1) == 1) begin
            {wv, hv} = {hv, wv};
        end
        mv = {7'(($urandom_range(0, 9) == 0) ? $urandom : 0), 2'($urandom_range(0, 3))};
        mask = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 7;
        if (phase_no == 3) begin
            mask = 7;
        end
        // registers in random order
        order = '{0, 1, 2};
        for (int k = 2; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < 3; k++) begin
            if (mask[order[k]]) begin
                case (order[k])
                    0: write_cfg(CFG_IMAGE_WIDTH, wv);
                    1: write_cfg(CFG_IMAGE_HEIGHT, hv);
                    default: write_cfg(CFG_ROTATION_MODE, mv);
                endcase
            end
        end
        finish_cfg();
        s_lvl = $urandom_range(0, 2);
        m_lvl = $urandom_range(0, 2);
        npix  = dim_in_use(tb_width) * dim_in_use(tb_height);
        nseg  = $urandom_range(1, 3);
        // keep the request count near the target
        while (nseg > 1 && counted_items + nseg * 2 * npix > RANDOM_ITEMS) begin
            nseg--;
        end
        for (int s = 0; s < nseg; s++) begin
            // only the closing segment may leave the frame dirty
            kind = (s == nseg - 1) ? $urandom_range(0, 9) : 0;
            if (kind <= 6) begin
                queue_frame(npix);
            end else if (kind <= 8) begin
                // frame cut short, aborted by the next register write
                nload = $urandom_range(0, npix);
                for (int k = 0; k < nload; k++) begin
                    push_req(FUNC_LOAD, rand_pixel(), 1'b1);
                end
                ndrain = (nload == npix) ? $urandom_range(0, npix - 1) : $urandom_range(0, 3);
                for (int k = 0; k < ndrain; k++) begin
                    push_req(FUNC_DRAIN, rand_pixel(), 1'b0);
                end
            end else begin
                // noise: random mix of loads and drains
                nload = $urandom_range(5, 30);
                for (int k = 0; k < nload; k++) begin
                    push_req(1'($urandom_range(0, 1)), rand_pixel(), 1'b0);
                end
            end
        end
        wait_idle();
    endtask

    // stimulus
    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset setting: drain on an empty frame, then a lone load
        push_req(FUNC_DRAIN, 24'h000000, 1'b0);
        push_req(FUNC_LOAD, 24'hFFFFFF, 1'b0);
        wait_idle();

        // 3 x 2 rotated ninety: extreme pixels, early drain, dropped load
        write_cfg(CFG_IMAGE_WIDTH, DIM_W'(3));
        write_cfg(CFG_IMAGE_HEIGHT, DIM_W'(2));
        write_cfg(CFG_ROTATION_MODE, DIM_W'(ROT_90));
        finish_cfg();
        push_req(FUNC_LOAD, 24'h000000, 1'b0);
        push_req(FUNC_LOAD, 24'hFFFFFF, 1'b0);
        push_req(FUNC_LOAD, 24'h0000FF, 1'b0);
        push_req(FUNC_LOAD, 24'h00FF00, 1'b0);
        push_req(FUNC_LOAD, 24'hFF0000, 1'b0);
        push_req(FUNC_DRAIN, 24'hFFFFFF, 1'b0);
        push_req(FUNC_LOAD, 24'h3CA55A, 1'b0);
        push_req(FUNC_LOAD, 24'h123456, 1'b0);
        for (int k = 0; k < 6; k++) begin
            push_req(FUNC_DRAIN, 24'h000000, 1'b0);
        end
        wait_idle();

        // zero width acts as one, two seventy
        write_cfg(CFG_IMAGE_WIDTH, '0);
        write_cfg(CFG_ROTATION_MODE, DIM_W'(ROT_270));
        finish_cfg();
        push_req(FUNC_LOAD, 24'hA5A5A5, 1'b0);
        push_req(FUNC_LOAD, 24'h5A5A5A, 1'b0);
        push_req(FUNC_DRAIN, 24'h000000, 1'b0);
        push_req(FUNC_DRAIN, 24'h000000, 1'b0);
        wait_idle();

        // 2 x 1 turned one eighty
        write_cfg(CFG_IMAGE_WIDTH, DIM_W'(2));
        write_cfg(CFG_IMAGE_HEIGHT, DIM_W'(1));
        write_cfg(CFG_ROTATION_MODE, DIM_W'(ROT_180));
        finish_cfg();
        push_req(FUNC_LOAD, 24'h010203, 1'b0);
        push_req(FUNC_LOAD, 24'hFEFDFC, 1'b0);
        push_req(FUNC_DRAIN, 24'h000000, 1'b0);
        push_req(FUNC_DRAIN, 24'h000000, 1'b0);
        wait_idle();

        // random frames until enough requests have gone through
        for (int p = 0; counted_items < RANDOM_ITEMS; p++) begin
            random_phase(p);
        end

        wait_idle();
        repeat (10) @(negedge aclk);
        if (pixels_due.size() != 0) begin
            $display("%0d expected pixels never arrived", pixels_due.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
